### design/s2x_pkg.sv
// ----------------------------------------------------------------------------
// s2x_pkg
// shared types and constants of the scale2x upscaler core
// ----------------------------------------------------------------------------
package s2x_pkg;

  // configuration port
  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ACTIVE_WIDTH  = 1'b0,
    CFG_ACTIVE_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam int WIDTH_RESET  = 320;
  localparam int HEIGHT_RESET = 200;

  // position fields of a result beat
  localparam int POS_BITS = 10;

  // number of result slots one source pixel can release
  localparam int NUM_SLOTS = 4;

  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                done;
  } blk_tag_t;

endpackage

### design/s2x_pixel_if.sv
// ----------------------------------------------------------------------------
// s2x_pixel_if
// source pixel channel: valid, ready and one palette index per beat
// ----------------------------------------------------------------------------
interface s2x_pixel_if #(
  parameter int PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

### design/s2x_block_if.sv
// ----------------------------------------------------------------------------
// s2x_block_if
// result channel: one 2x2 output block with its source position per beat
// ----------------------------------------------------------------------------
interface s2x_block_if import s2x_pkg::*; #(
  parameter int PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] out_top_left;
  logic [PIXEL_BITS-1:0] out_top_right;
  logic [PIXEL_BITS-1:0] out_bottom_left;
  logic [PIXEL_BITS-1:0] out_bottom_right;
  logic [POS_BITS-1:0]   source_row;
  logic [POS_BITS-1:0]   source_column;
  logic                  last_in_run;
  logic                  frame_done;

  modport source (
    output valid, output out_top_left, output out_top_right,
    output out_bottom_left, output out_bottom_right,
    output source_row, output source_column, output last_in_run,
    output frame_done, input ready
  );
  modport sink (
    input valid, input out_top_left, input out_top_right,
    input out_bottom_left, input out_bottom_right,
    input source_row, input source_column, input last_in_run,
    input frame_done, output ready
  );
endinterface

### design/s2x_line_store.sv
// ----------------------------------------------------------------------------
// s2x_line_store
// one-write one-read line memory with registered read and write bypass
// ----------------------------------------------------------------------------
module s2x_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16
) (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [DW-1:0]                        wr_data_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [DW-1:0]                        rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // same-address read returns the word being written
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### design/s2x_kernel.sv
// ----------------------------------------------------------------------------
// s2x_kernel
// scale2x / epx rule: one centre pixel and four neighbours to a 2x2 block
// ----------------------------------------------------------------------------
module s2x_kernel #(
  parameter int PIXEL_BITS = 8
) (
  input  logic [PIXEL_BITS-1:0]      p_i,    // centre
  input  logic [PIXEL_BITS-1:0]      a_i,    // above
  input  logic [PIXEL_BITS-1:0]      l_i,    // left
  input  logic [PIXEL_BITS-1:0]      r_i,    // right
  input  logic [PIXEL_BITS-1:0]      d_i,    // below
  output logic [3:0][PIXEL_BITS-1:0] quad_o  // tl, tr, bl, br
);

  always_comb begin
    quad_o[0] = (l_i == a_i && a_i != d_i && l_i != r_i) ? a_i : p_i;
    quad_o[1] = (a_i == r_i && a_i != l_i && r_i != d_i) ? r_i : p_i;
    quad_o[2] = (l_i == d_i && d_i != a_i && l_i != r_i) ? l_i : p_i;
    quad_o[3] = (r_i == d_i && r_i != a_i && d_i != l_i) ? d_i : p_i;
  end

endmodule

### design/s2x_block_queue.sv
// ----------------------------------------------------------------------------
// s2x_block_queue
// holds the blocks released by one pixel and hands them out one per beat
// ----------------------------------------------------------------------------
module s2x_block_queue import s2x_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [NUM_SLOTS-1:0]       mask_i,
  input  logic [3:0][PIXEL_BITS-1:0] pix_i [NUM_SLOTS],
  input  blk_tag_t                   tag_i [NUM_SLOTS],
  output logic                       ready_o,
  s2x_block_if.source                blk_o
);

  logic [NUM_SLOTS-1:0]       pend_q, pend_d;
  logic [3:0][PIXEL_BITS-1:0] ent_pix_q [NUM_SLOTS];
  blk_tag_t                   ent_tag_q [NUM_SLOTS];

  logic                       out_vld_q, out_vld_d;
  logic [3:0][PIXEL_BITS-1:0] out_pix_q;
  blk_tag_t                   out_tag_q;
  logic                       out_last_q;

  logic [$clog2(NUM_SLOTS)-1:0] sel_idx;
  logic [NUM_SLOTS-1:0]         sel_oh;
  logic [NUM_SLOTS-1:0]         rest;
  logic                         move;

  // lowest pending slot goes first
  always_comb begin
    sel_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_idx = ($clog2(NUM_SLOTS))'(i);
      end
    end
  end

  assign sel_oh  = NUM_SLOTS'(1) << sel_idx;
  assign rest    = pend_q & ~sel_oh;
  assign move    = (pend_q != '0) && (!out_vld_q || blk_o.ready);
  assign ready_o = (pend_q == '0) || (move && (rest == '0));

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      pend_d = mask_i;
    end else if (move) begin
      pend_d = rest;
    end
    out_vld_d = out_vld_q;
    if (move) begin
      out_vld_d = 1'b1;
    end else if (blk_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_pix_q <= pix_i;
      ent_tag_q <= tag_i;
    end
    if (move) begin
      out_pix_q  <= ent_pix_q[sel_idx];
      out_tag_q  <= ent_tag_q[sel_idx];
      out_last_q <= (rest == '0);
    end
  end

  assign blk_o.valid            = out_vld_q;
  assign blk_o.out_top_left     = out_pix_q[0];
  assign blk_o.out_top_right    = out_pix_q[1];
  assign blk_o.out_bottom_left  = out_pix_q[2];
  assign blk_o.out_bottom_right = out_pix_q[3];
  assign blk_o.source_row       = out_tag_q.row;
  assign blk_o.source_column    = out_tag_q.col;
  assign blk_o.last_in_run      = out_last_q;
  assign blk_o.frame_done       = out_tag_q.done;

endmodule

### design/scale2x_pixel_upscaler_core.sv
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler_core
// streaming scale2x / epx 2x upscaler for indexed pixels
// ----------------------------------------------------------------------------
// usage
//  - pix_i takes one source palette index per beat, raster order, for a frame
//    of active_width x active_height pixels (config port, index 0 and 1)
//  - blk_o gives one 2x2 output block per beat with its source row/column;
//    last_in_run marks the final block a pixel releases, frame_done the block
//    of the frame's last pixel
//  - a block leaves once its right and lower neighbours are in; the last
//    column and the last row are released early, so one pixel gives 0 to 4
//    beats
//  - a released block passes the slot queue, then the result register, to blk_o
//  - throughput: one pixel per cycle while blk_o is ready and no pixel
//    releases more than one block; with n blocks the input waits until the
//    single result register has taken them, one block per cycle from the queue
//  - a stalled receiver holds the result register; one more pixel's blocks
//    wait in the slot queue, then pix_i.ready drops
//  - reset: frame position to zero, size 320 x 200, line store not cleared
//  - a config write restarts the frame; write only while idle
// ----------------------------------------------------------------------------
module scale2x_pixel_upscaler_core import s2x_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  s2x_pixel_if.sink               pix_i,
  s2x_block_if.source             blk_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WBITS = $clog2(MAX_WIDTH + 1);
  localparam int HBITS = $clog2(MAX_HEIGHT + 1);
  localparam int PB    = PIXEL_BITS;
  localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  // frame size, held already clamped to 1..max
  logic [WBITS-1:0] width_q, width_d;
  logic [HBITS-1:0] height_q, height_d;

  // frame position of the next pixel
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // current row: the two pixels left of the next one
  logic [PB-1:0] lag1_q, lag1_d, lag2_q, lag2_d;

  // row above: columns c-1, c-2; two rows above: column c-1
  logic [PB-1:0] p1_q, p2_q, o1_q;

  logic          accept;
  logic          queue_ready;
  logic          last_col, last_row;
  logic          col_gt0, col_gt1, row_gt0, row_gt1;
  logic [CW-1:0] col_next;
  logic [CW-1:0] rd_addr;
  logic [2*PB-1:0] rd_word;
  logic [PB-1:0] rd_prev, rd_old;
  logic [PB-1:0] px;

  logic [WBITS-1:0] cfg_w;
  logic [HBITS-1:0] cfg_h;

  assign px     = pix_i.pixel;
  assign accept = pix_i.valid && queue_ready;
  assign pix_i.ready = queue_ready;

  // line store word: {two rows above, row above} at each column
  assign rd_prev = rd_word[PB-1:0];
  assign rd_old  = rd_word[2*PB-1:PB];

  assign last_col = ((WBITS'(col_q) + WBITS'(1)) == width_q);
  assign last_row = ((HBITS'(row_q) + HBITS'(1)) == height_q);
  assign col_gt0  = (col_q != '0);
  assign col_gt1  = (col_q > CW'(1));
  assign row_gt0  = (row_q != '0);
  assign row_gt1  = (row_q > RW'(1));
  assign col_next = last_col ? '0 : col_q + CW'(1);

  // read one column ahead so the word of the next pixel is ready on accept
  always_comb begin
    if (cfg_we_i) begin
      rd_addr = '0;
    end else if (accept) begin
      rd_addr = col_next;
    end else begin
      rd_addr = col_q;
    end
  end

  s2x_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PB)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (col_q),
    .wr_data_i ({rd_prev, px}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word)
  );

  // clamp of a written size: zero acts as one, oversize as the maximum
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_w = WBITS'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
      cfg_w = WBITS'(MAX_WIDTH);
    end else begin
      cfg_w = WBITS'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      cfg_h = HBITS'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_HEIGHT)) begin
      cfg_h = HBITS'(MAX_HEIGHT);
    end else begin
      cfg_h = HBITS'(cfg_data_i);
    end
  end

  // neighbour selection for the four release slots
  logic [PB-1:0]           k_p [NUM_SLOTS];
  logic [PB-1:0]           k_a [NUM_SLOTS];
  logic [PB-1:0]           k_l [NUM_SLOTS];
  logic [PB-1:0]           k_r [NUM_SLOTS];
  logic [PB-1:0]           k_d [NUM_SLOTS];
  logic [3:0][PB-1:0]      k_quad [NUM_SLOTS];
  blk_tag_t                k_tag [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    k_mask;

  always_comb begin
    // block above-left, released once its lower neighbour is in
    k_p[0]   = p1_q;
    k_a[0]   = row_gt1 ? o1_q : p1_q;
    k_l[0]   = col_gt1 ? p2_q : p1_q;
    k_r[0]   = rd_prev;
    k_d[0]   = lag1_q;
    k_tag[0] = '{row: POS_BITS'(row_q - RW'(1)), col: POS_BITS'(col_q - CW'(1)),
                 done: 1'b0};
    // block above, last column of the row above
    k_p[1]   = rd_prev;
    k_a[1]   = row_gt1 ? rd_old : rd_prev;
    k_l[1]   = col_gt0 ? p1_q : rd_prev;
    k_r[1]   = rd_prev;
    k_d[1]   = px;
    k_tag[1] = '{row: POS_BITS'(row_q - RW'(1)), col: POS_BITS'(col_q), done: 1'b0};
    // block left, last row: no lower neighbour
    k_p[2]   = lag1_q;
    k_a[2]   = row_gt0 ? p1_q : lag1_q;
    k_l[2]   = col_gt1 ? lag2_q : lag1_q;
    k_r[2]   = px;
    k_d[2]   = lag1_q;
    k_tag[2] = '{row: POS_BITS'(row_q), col: POS_BITS'(col_q - CW'(1)), done: 1'b0};
    // the frame's last pixel itself
    k_p[3]   = px;
    k_a[3]   = row_gt0 ? rd_prev : px;
    k_l[3]   = col_gt0 ? lag1_q : px;
    k_r[3]   = px;
    k_d[3]   = px;
    k_tag[3] = '{row: POS_BITS'(row_q), col: POS_BITS'(col_q), done: 1'b1};

    k_mask[0] = row_gt0 && col_gt0;
    k_mask[1] = row_gt0 && last_col;
    k_mask[2] = last_row && col_gt0;
    k_mask[3] = last_row && last_col;
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_kernel
    s2x_kernel #(
      .PIXEL_BITS (PB)
    ) u_kernel (
      .p_i    (k_p[g]),
      .a_i    (k_a[g]),
      .l_i    (k_l[g]),
      .r_i    (k_r[g]),
      .d_i    (k_d[g]),
      .quad_o (k_quad[g])
    );
  end

  s2x_block_queue #(
    .PIXEL_BITS (PB)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .mask_i  (k_mask),
    .pix_i   (k_quad),
    .tag_i   (k_tag),
    .ready_o (queue_ready),
    .blk_o   (blk_o)
  );

  // frame position, row lag and size registers
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    lag1_d   = lag1_q;
    lag2_d   = lag2_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ACTIVE_WIDTH:  width_d  = cfg_w;
        CFG_ACTIVE_HEIGHT: height_d = cfg_h;
      endcase
      col_d  = '0;
      row_d  = '0;
      lag1_d = '0;
      lag2_d = '0;
    end else if (accept) begin
      col_d  = col_next;
      lag1_d = px;
      lag2_d = lag1_q;
      if (last_col) begin
        lag1_d = '0;
        lag2_d = '0;
        row_d  = last_row ? '0 : row_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WBITS'(W_RST);
      height_q <= HBITS'(H_RST);
      col_q    <= '0;
      row_q    <= '0;
      lag1_q   <= '0;
      lag2_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      lag1_q   <= lag1_d;
      lag2_q   <= lag2_d;
    end
  end

  // sliding window over the rows above
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p2_q <= p1_q;
      p1_q <= rd_prev;
      o1_q <= rd_old;
    end
  end

endmodule
